// ===== hdl/balcpid_pkg.sv =====
package balcpid_pkg;

   // field widths
   localparam int GAIN_W   = 24;
   localparam int ANGLE_W  = 17;
   localparam int SPEED_W  = 16;
   localparam int RATE_W   = 16;
   localparam int DIST_W   = 16;
   localparam int LIMIT_W  = 16;
   localparam int DRIVE_W  = 17;
   localparam int SGOAL_W  = 5;
   localparam int TGOAL_W  = 9;

   // shared multiplier operand and product widths
   localparam int MUL_A_W  = 25;
   localparam int MUL_B_W  = 20;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_UPRIGHT_KP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPRIGHT_KD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_KP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_KI      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_KP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BALANCE_ANGLE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_LIMIT     = 3'd6;

   localparam int PWM_LIMIT_RESET = 7200;

   // control constants
   localparam int SPEED_GOAL_MAX = 12;
   localparam int TURN_GOAL_MAX  = 150;
   localparam int TURN_STEP      = 30;
   localparam int OBSTACLE_NEAR  = 50;
   localparam int INTEGRAL_MAX   = 20000;
   localparam int YAW_GAIN       = 24576;   // 0.6 * 40960

   // x / 10 as (x * RECIP10) >> RECIP10_SHIFT plus one correction step
   localparam int RECIP10       = 209715;
   localparam int RECIP10_SHIFT = 21;

   typedef logic signed [GAIN_W-1:0]  gain_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [SPEED_W-1:0] speed_type;
   typedef logic signed [RATE_W-1:0]  rate_type;
   typedef logic [DIST_W-1:0]         dist_type;
   typedef logic [LIMIT_W-1:0]        limit_type;
   typedef logic signed [DRIVE_W-1:0] drive_type;
   typedef logic signed [SGOAL_W-1:0] sgoal_type;
   typedef logic signed [TGOAL_W-1:0] tgoal_type;

   typedef logic signed [MUL_A_W-1:0] mul_a_type;
   typedef logic signed [MUL_B_W-1:0] mul_b_type;
   typedef logic signed [MUL_P_W-1:0] mul_p_type;

   typedef struct packed {
      logic fwd;
      logic back;
      logic turn_left;
      logic turn_right;
   } btn_type;

endpackage

// ===== hdl/balcpid_req_if.sv =====
interface balcpid_req_if;
   import balcpid_pkg::*;

   logic      valid;
   logic      ready;
   speed_type left_speed;
   speed_type right_speed;
   angle_type roll_angle;
   rate_type  pitch_rate;
   rate_type  yaw_rate;
   logic      fwd_button;
   logic      back_button;
   logic      left_button;
   logic      right_button;
   dist_type  obstacle_cm;
   logic      integral_clear;

   modport source (
      output valid, left_speed, right_speed, roll_angle, pitch_rate, yaw_rate,
             fwd_button, back_button, left_button, right_button, obstacle_cm,
             integral_clear,
      input  ready
   );

   modport sink (
      input  valid, left_speed, right_speed, roll_angle, pitch_rate, yaw_rate,
             fwd_button, back_button, left_button, right_button, obstacle_cm,
             integral_clear,
      output ready
   );

endinterface

// ===== hdl/balcpid_rsp_if.sv =====
interface balcpid_rsp_if;
   import balcpid_pkg::*;

   logic      valid;
   logic      ready;
   drive_type left_drive;
   drive_type right_drive;

   modport source (
      output valid, left_drive, right_drive,
      input  ready
   );

   modport sink (
      input  valid, left_drive, right_drive,
      output ready
   );

endinterface

// ===== hdl/balcpid_mul.sv =====
module balcpid_mul (
   input  logic                  clock,
   input  balcpid_pkg::mul_a_type a,
   input  balcpid_pkg::mul_b_type b,
   output balcpid_pkg::mul_p_type product
);
   import balcpid_pkg::*;

   mul_p_type product_ff;

   // signed multiply, registered
   always_ff @(posedge clock) begin
      product_ff <= MUL_P_W'(a) * MUL_P_W'(b);
   end

   assign product = product_ff;

endmodule

// ===== hdl/balcpid_goal.sv =====
module balcpid_goal (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   update,
   input  balcpid_pkg::btn_type   btn,
   input  balcpid_pkg::dist_type  obstacle_cm,
   output balcpid_pkg::sgoal_type speed_goal,
   output balcpid_pkg::tgoal_type turn_goal
);
   import balcpid_pkg::*;

   localparam logic signed [SGOAL_W:0]   SG_HI = (SGOAL_W+1)'(SPEED_GOAL_MAX);
   localparam logic signed [SGOAL_W:0]   SG_LO = -SG_HI;
   localparam logic signed [TGOAL_W:0]   TG_HI = (TGOAL_W+1)'(TURN_GOAL_MAX);
   localparam logic signed [TGOAL_W:0]   TG_LO = -TG_HI;
   localparam logic signed [TGOAL_W:0]   TG_STEP = (TGOAL_W+1)'(TURN_STEP);

   sgoal_type speed_goal_ff, speed_goal_in;
   tgoal_type turn_goal_ff, turn_goal_in;

   logic signed [SGOAL_W:0] sg_sum;
   logic signed [TGOAL_W:0] tg_sum;
   logic                    near;

   always_comb begin
      near = obstacle_cm < DIST_W'(OBSTACLE_NEAR);

      // speed ramp: released buttons drop the target to zero
      sg_sum = (btn.fwd || btn.back) ? {speed_goal_ff[SGOAL_W-1], speed_goal_ff} : '0;
      if (btn.fwd) begin
         sg_sum = near ? sg_sum + (SGOAL_W+1)'(1) : sg_sum - (SGOAL_W+1)'(1);
      end
      if (btn.back) begin
         sg_sum = sg_sum + (SGOAL_W+1)'(1);
      end
      if (sg_sum > SG_HI) begin
         speed_goal_in = SG_HI[SGOAL_W-1:0];
      end else if (sg_sum < SG_LO) begin
         speed_goal_in = SG_LO[SGOAL_W-1:0];
      end else begin
         speed_goal_in = sg_sum[SGOAL_W-1:0];
      end

      // turn steps
      tg_sum = (btn.turn_left || btn.turn_right) ?
               {turn_goal_ff[TGOAL_W-1], turn_goal_ff} : '0;
      if (btn.turn_left) begin
         tg_sum = tg_sum + TG_STEP;
      end
      if (btn.turn_right) begin
         tg_sum = tg_sum - TG_STEP;
      end
      if (tg_sum > TG_HI) begin
         turn_goal_in = TG_HI[TGOAL_W-1:0];
      end else if (tg_sum < TG_LO) begin
         turn_goal_in = TG_LO[TGOAL_W-1:0];
      end else begin
         turn_goal_in = tg_sum[TGOAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_goal_ff <= '0;
         turn_goal_ff  <= '0;
      end else if (update) begin
         speed_goal_ff <= speed_goal_in;
         turn_goal_ff  <= turn_goal_in;
      end
   end

   assign speed_goal = speed_goal_ff;
   assign turn_goal  = turn_goal_ff;

endmodule

// ===== hdl/balance_cascade_pid_unit.sv =====
// A request is taken only while the sequencer is idle, so a new request waits until the
// previous result is loaded into the output slot; the sequencer walks ten products
// through one registered 25x20 multiplier plus two divide-by-ten fixups.
// Reset (synchronous, active high) clears the sequencer, the output valid,
// goals, filter and integral state; pwm_limit returns to 7200, gains to 0.
module balance_cascade_pid_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [balcpid_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [balcpid_pkg::CSR_DATA_W-1:0]    csr_wdata,
   balcpid_req_if.sink                           req_ch,
   balcpid_rsp_if.source                         rsp_ch
);
   import balcpid_pkg::*;

   // sequencer codes
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_ERR   = 5'd1;
   localparam logic [4:0] ST_F_MUL = 5'd2;
   localparam logic [4:0] ST_F_Q   = 5'd3;
   localparam logic [4:0] ST_F_FIX = 5'd4;
   localparam logic [4:0] ST_INT   = 5'd5;
   localparam logic [4:0] ST_VEL1  = 5'd6;
   localparam logic [4:0] ST_VEL2  = 5'd7;
   localparam logic [4:0] ST_VEL3  = 5'd8;
   localparam logic [4:0] ST_UP1   = 5'd9;
   localparam logic [4:0] ST_UP2   = 5'd10;
   localparam logic [4:0] ST_UP3   = 5'd11;
   localparam logic [4:0] ST_UP4   = 5'd12;
   localparam logic [4:0] ST_UP5   = 5'd13;
   localparam logic [4:0] ST_TURN1 = 5'd14;
   localparam logic [4:0] ST_TURN2 = 5'd15;
   localparam logic [4:0] ST_T_MUL = 5'd16;
   localparam logic [4:0] ST_T_Q   = 5'd17;
   localparam logic [4:0] ST_T_FIX = 5'd18;
   localparam logic [4:0] ST_OUT   = 5'd19;

   localparam int ACC_W  = 64;
   localparam int FERR_W = 18;   // filtered error stays inside +-65548
   localparam int NUM_W  = 22;   // 3*err + 7*filtered
   localparam int DMAG_W = 22;   // divide-by-ten dividend magnitude
   localparam int Q_W    = 19;   // divide-by-ten quotient magnitude
   localparam int INT_W  = 16;
   localparam int VEL_W  = 30;
   localparam int VL_W   = 15;   // low, unsigned slice of vel
   localparam int UP_W   = 44;
   localparam int TURN_W = Q_W + 1;
   localparam int SAT_W  = UP_W + 1;

   localparam logic signed [INT_W+2:0] INT_HI = (INT_W+3)'(INTEGRAL_MAX);
   localparam logic signed [INT_W+2:0] INT_LO = -INT_HI;

   // ---------------------------------------------------------------- config
   gain_type  upright_kp_ff, upright_kd_ff, speed_kp_ff, speed_ki_ff, steer_kp_ff;
   angle_type balance_angle_ff;
   limit_type pwm_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upright_kp_ff    <= '0;
         upright_kd_ff    <= '0;
         speed_kp_ff      <= '0;
         speed_ki_ff      <= '0;
         steer_kp_ff      <= '0;
         balance_angle_ff <= '0;
         pwm_limit_ff     <= LIMIT_W'(PWM_LIMIT_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_UPRIGHT_KP:    upright_kp_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_UPRIGHT_KD:    upright_kd_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_SPEED_KP:      speed_kp_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_SPEED_KI:      speed_ki_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_STEER_KP:      steer_kp_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_BALANCE_ANGLE: balance_angle_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_PWM_LIMIT:     pwm_limit_ff     <= csr_wdata[LIMIT_W-1:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   logic [4:0] state_ff, state_in;
   logic       req_xfer;
   logic       rsp_load;
   logic       rsp_valid_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   // result slot frees up when empty or being taken this cycle
   assign rsp_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_ERR;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERR, ST_F_MUL, ST_F_Q, ST_F_FIX, ST_INT, ST_VEL1, ST_VEL2, ST_VEL3,
         ST_UP1, ST_UP2, ST_UP3, ST_UP4, ST_UP5, ST_TURN1, ST_TURN2, ST_T_MUL,
         ST_T_Q, ST_T_FIX: begin
            state_in = state_ff + 5'd1;   // straight-line microcode
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- goals
   btn_type   btn;
   sgoal_type speed_goal;
   tgoal_type turn_goal;

   assign btn.fwd        = req_ch.fwd_button;
   assign btn.back       = req_ch.back_button;
   assign btn.turn_left  = req_ch.left_button;
   assign btn.turn_right = req_ch.right_button;

   balcpid_goal u_goal (
      .clock       (clock),
      .reset       (reset),
      .update      (req_xfer),
      .btn         (btn),
      .obstacle_cm (req_ch.obstacle_cm),
      .speed_goal  (speed_goal),
      .turn_goal   (turn_goal)
   );

   // ---------------------------------------------------------------- request capture
   speed_type ls_ff, rs_ff;
   angle_type roll_ff;
   rate_type  pitch_ff, yaw_ff;
   logic      clr_ff, steering_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ls_ff       <= req_ch.left_speed;
         rs_ff       <= req_ch.right_speed;
         roll_ff     <= req_ch.roll_angle;
         pitch_ff    <= req_ch.pitch_rate;
         yaw_ff      <= req_ch.yaw_rate;
         clr_ff      <= req_ch.integral_clear;
         // yaw damping only while no turn button is held
         steering_ff <= req_ch.left_button || req_ch.right_button;
      end
   end

   // ---------------------------------------------------------------- datapath
   logic signed [FERR_W-1:0] ferr_ff;
   logic signed [INT_W-1:0]  integ_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [VEL_W-1:0]  vel_ff;
   logic signed [UP_W-1:0]   up_ff;
   logic signed [TURN_W-1:0] turn_ff;
   logic [DMAG_W-1:0]        dmag_ff;
   logic                     dneg_ff;
   logic [Q_W-1:0]           q0_ff;

   mul_a_type mul_a;
   mul_b_type mul_b;
   mul_p_type product;
   logic signed [ACC_W-1:0] prod_x;

   balcpid_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (product)
   );

   assign prod_x = {{(ACC_W-MUL_P_W){product[MUL_P_W-1]}}, product};

   // truncate toward zero on an arithmetic right shift
   function automatic logic signed [ACC_W-1:0] trunc_shr(
      input logic signed [ACC_W-1:0] v,
      input logic [4:0]              k
   );
      logic signed [ACC_W-1:0] bias;
      bias = v[ACC_W-1] ? ((ACC_W'(1) <<< k) - ACC_W'(1)) : '0;
      return (v + bias) >>> k;
   endfunction

   // error and filter numerator
   logic signed [FERR_W-1:0] err;
   logic signed [NUM_W-1:0]  err_x, ferr_x, num;

   always_comb begin
      err    = {{2{ls_ff[SPEED_W-1]}}, ls_ff} + {{2{rs_ff[SPEED_W-1]}}, rs_ff}
               - {{(FERR_W-SGOAL_W){speed_goal[SGOAL_W-1]}}, speed_goal};
      err_x  = {{(NUM_W-FERR_W){err[FERR_W-1]}}, err};
      ferr_x = {{(NUM_W-FERR_W){ferr_ff[FERR_W-1]}}, ferr_ff};
      num    = (err_x <<< 1) + err_x + (ferr_x <<< 3) - ferr_x;
   end

   // divide-by-ten fixup: quotient estimate is low by at most one
   logic [DMAG_W:0]          q10, rem;
   logic [Q_W-1:0]           qc;
   logic signed [TURN_W-1:0] qs;

   always_comb begin
      q10 = {1'b0, q0_ff, 3'b000} + {3'b000, q0_ff, 1'b0};
      rem = {1'b0, dmag_ff} - q10;
      qc  = q0_ff + Q_W'(rem >= (DMAG_W+1)'(10));
      qs  = dneg_ff ? -{1'b0, qc} : {1'b0, qc};
   end

   // integral update, then clamp, then optional clear
   logic signed [INT_W+2:0] integ_sum;
   logic signed [INT_W-1:0] integ_in;

   always_comb begin
      integ_sum = {{3{integ_ff[INT_W-1]}}, integ_ff}
                  + {{(INT_W+3-FERR_W){ferr_ff[FERR_W-1]}}, ferr_ff};
      if (clr_ff) begin
         integ_in = '0;
      end else if (integ_sum > INT_HI) begin
         integ_in = INT_HI[INT_W-1:0];
      end else if (integ_sum < INT_LO) begin
         integ_in = INT_LO[INT_W-1:0];
      end else begin
         integ_in = integ_sum[INT_W-1:0];
      end
   end

   // multiplier operand select
   logic signed [ANGLE_W:0] tilt;
   logic signed [11:0]      tg_x, tg10;

   always_comb begin
      tilt = {roll_ff[ANGLE_W-1], roll_ff} - {balance_angle_ff[ANGLE_W-1], balance_angle_ff};
      tg_x = {{(12-TGOAL_W){turn_goal[TGOAL_W-1]}}, turn_goal};
      tg10 = (tg_x <<< 3) + (tg_x <<< 1);

      mul_a = {1'b0, {(MUL_A_W-1-DMAG_W){1'b0}}, dmag_ff};
      mul_b = MUL_B_W'(RECIP10);
      case (state_ff)
         ST_INT: begin
            mul_a = {speed_kp_ff[GAIN_W-1], speed_kp_ff};
            mul_b = {{(MUL_B_W-FERR_W){ferr_ff[FERR_W-1]}}, ferr_ff};
         end
         ST_VEL1: begin
            mul_a = {speed_ki_ff[GAIN_W-1], speed_ki_ff};
            mul_b = {{(MUL_B_W-INT_W){integ_ff[INT_W-1]}}, integ_ff};
         end
         ST_VEL3: begin
            mul_a = {upright_kp_ff[GAIN_W-1], upright_kp_ff};
            mul_b = {{(MUL_B_W-ANGLE_W-1){tilt[ANGLE_W]}}, tilt};
         end
         ST_UP1: begin
            mul_a = {upright_kd_ff[GAIN_W-1], upright_kd_ff};
            mul_b = {{(MUL_B_W-RATE_W){pitch_ff[RATE_W-1]}}, pitch_ff};
         end
         ST_UP2: begin
            // high, signed part of vel
            mul_a = {upright_kp_ff[GAIN_W-1], upright_kp_ff};
            mul_b = {{(MUL_B_W-VEL_W+VL_W){vel_ff[VEL_W-1]}}, vel_ff[VEL_W-1:VL_W]};
         end
         ST_UP3: begin
            // low, unsigned part of vel
            mul_a = {upright_kp_ff[GAIN_W-1], upright_kp_ff};
            mul_b = {{(MUL_B_W-VL_W){1'b0}}, vel_ff[VL_W-1:0]};
         end
         ST_UP4: begin
            mul_a = {steer_kp_ff[GAIN_W-1], steer_kp_ff};
            mul_b = {{(MUL_B_W-12){tg10[11]}}, tg10};
         end
         ST_UP5: begin
            mul_a = MUL_A_W'(YAW_GAIN);
            mul_b = {{(MUL_B_W-RATE_W){yaw_ff[RATE_W-1]}}, yaw_ff};
         end
         default: ;   // dividend times reciprocal of ten
      endcase
   end

   // turn magnitude for the second divide-by-ten
   logic signed [ACC_W-1:0] acc_abs;
   assign acc_abs = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;

   logic signed [ACC_W-1:0] vel_full, up_full;
   assign vel_full = trunc_shr(acc_ff, 5'd12);
   assign up_full  = trunc_shr(acc_ff, 5'd20);

   always_ff @(posedge clock) begin
      if (reset) begin
         ferr_ff  <= '0;
         integ_ff <= '0;
      end else begin
         case (state_ff)
            ST_F_FIX: ferr_ff  <= qs[FERR_W-1:0];
            ST_INT:   integ_ff <= integ_in;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff) inside
         ST_ERR: begin
            dneg_ff <= num[NUM_W-1];
            dmag_ff <= num[NUM_W-1] ? DMAG_W'(-num) : DMAG_W'(num);
         end
         ST_F_Q, ST_T_Q: begin
            q0_ff <= product[RECIP10_SHIFT+Q_W-1:RECIP10_SHIFT];
         end
         ST_VEL1:  acc_ff <= prod_x;
         ST_VEL2:  acc_ff <= acc_ff + prod_x;
         ST_VEL3:  vel_ff <= vel_full[VEL_W-1:0];
         ST_UP1:   acc_ff <= prod_x;
         ST_UP2:   acc_ff <= acc_ff + (prod_x <<< 8);
         ST_UP3:   acc_ff <= acc_ff - (prod_x <<< 23);
         ST_UP4:   acc_ff <= acc_ff - (prod_x <<< 8);
         ST_UP5: begin
            up_ff  <= up_full[UP_W-1:0];
            acc_ff <= prod_x;
         end
         ST_TURN1: begin
            if (!steering_ff) begin
               acc_ff <= acc_ff + prod_x;
            end
         end
         ST_TURN2: begin
            // |trunc(x / 4096)| = |x| >> 12; the /10 follows
            dneg_ff <= acc_ff[ACC_W-1];
            dmag_ff <= acc_abs[DMAG_W+11:12];
         end
         ST_T_FIX: turn_ff <= qs;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- output
   logic signed [SAT_W-1:0] up_x, turn_x, lim, l_sum, r_sum;
   drive_type               l_sat, r_sat;
   drive_type               left_drive_ff, right_drive_ff;

   always_comb begin
      up_x   = {up_ff[UP_W-1], up_ff};
      turn_x = {{(SAT_W-TURN_W){turn_ff[TURN_W-1]}}, turn_ff};
      lim    = {{(SAT_W-LIMIT_W){1'b0}}, pwm_limit_ff};
      l_sum  = up_x - turn_x;
      r_sum  = up_x + turn_x;
      if (l_sum > lim) begin
         l_sat = lim[DRIVE_W-1:0];
      end else if (l_sum < -lim) begin
         l_sat = DRIVE_W'(-lim);
      end else begin
         l_sat = l_sum[DRIVE_W-1:0];
      end
      if (r_sum > lim) begin
         r_sat = lim[DRIVE_W-1:0];
      end else if (r_sum < -lim) begin
         r_sat = DRIVE_W'(-lim);
      end else begin
         r_sat = r_sum[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         left_drive_ff  <= l_sat;
         right_drive_ff <= r_sat;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.left_drive  = left_drive_ff;
   assign rsp_ch.right_drive = right_drive_ff;

endmodule
